/* design/jmsd_pkg.sv */
package jmsd_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hCF;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  // Fixed part of a frame header length, before the component entries.
  localparam logic [9:0] SOF_BASE_LEN = 10'd8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_START = 2'd1,
    ST_LEN   = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [10:0] {
    PH_FF1     = 11'b000_0000_0001,
    PH_SOI     = 11'b000_0000_0010,
    PH_HUNT    = 11'b000_0000_0100,
    PH_CODE    = 11'b000_0000_1000,
    PH_SKLEN_H = 11'b000_0001_0000,
    PH_SKLEN_L = 11'b000_0010_0000,
    PH_SKIP    = 11'b000_0100_0000,
    PH_FLEN_H  = 11'b000_1000_0000,
    PH_FLEN_L  = 11'b001_0000_0000,
    PH_FIELDS  = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_t;

  // Frame header fields in arrival order after the length.
  localparam logic [2:0] FLD_PRECISION = 3'd0;
  localparam logic [2:0] FLD_HEIGHT_H  = 3'd1;
  localparam logic [2:0] FLD_HEIGHT_L  = 3'd2;
  localparam logic [2:0] FLD_WIDTH_H   = 3'd3;
  localparam logic [2:0] FLD_WIDTH_L   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic        frame_seen;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  sample_precision;
    logic [7:0]  component_count;
    logic [7:0]  frame_kind;
  } out_word_t;

  function automatic logic is_frame_code(input logic [7:0] c);
    return (c >= MARK_SOF_LO) && (c <= MARK_SOF_HI) &&
           (c != MARK_DHT) && (c != MARK_JPG) && (c != MARK_DAC);
  endfunction

endpackage

/* design/jmsd_stream_if.sv */
interface jmsd_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/jpeg_marker_scan_dimensions_core.sv */
// Channel  | Dir | Word                                     | Transfer
// ---------+-----+------------------------------------------+------------------
// stream   | in  | data_byte[8], end_of_data[1]             | valid && ready
// report   | out | parse_status[2], frame_seen, image_width, | valid && ready
//          |     | image_height, sample_precision,           |
//          |     | component_count, frame_kind               |
//
// One input word per cycle while the skid entry is free; a result, when a word
// causes one, is registered at the edge that takes the word; in the output register
// it can leave at the next. The parse state updates in the cycle of the transfer.
// A two-entry output (register plus skid) keeps stream.ready high while a
// single result waits; ready drops only when both entries are full.
// rst is synchronous, active high; after it the parser expects the first FF.
module jpeg_marker_scan_dimensions_core
  import jmsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  jmsd_stream_if.sink         stream,
  jmsd_stream_if.source       report
);

  // Parser state
  phase_t      phase;
  logic [15:0] segment_length;
  logic [15:0] bytes_to_skip;
  logic [2:0]  field_index;
  logic [7:0]  high_byte_hold;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  precision_reg;
  logic [7:0]  components_reg;
  logic [7:0]  frame_code_reg;
  logic        frame_flag;

  phase_t      phase_next;
  logic [15:0] segment_length_next;
  logic [15:0] bytes_to_skip_next;
  logic [2:0]  field_index_next;
  logic [7:0]  high_byte_hold_next;
  logic [15:0] width_reg_next;
  logic [15:0] height_reg_next;
  logic [7:0]  precision_reg_next;
  logic [7:0]  components_reg_next;
  logic [7:0]  frame_code_reg_next;
  logic        frame_flag_next;

  // Output buffering
  logic      out_valid;
  out_word_t out_word;
  logic      skid_valid;
  out_word_t skid_word;

  logic        accept;
  logic        take;
  logic        emit;
  status_t     status;
  out_word_t   result_word;
  logic [7:0]  b;
  logic        eod;
  logic [15:0] len_word;
  logic [15:0] skip_dec;
  logic [9:0]  comp_bytes;
  logic [9:0]  frame_len_want;

  assign b        = stream.data.data_byte;
  assign eod      = stream.data.end_of_data;
  assign len_word = {high_byte_hold, b};
  assign skip_dec = bytes_to_skip - 16'd1;
  // 3*n as n + 2n: at most 765, fits in ten bits
  assign comp_bytes     = {2'b00, b} + {1'b0, b, 1'b0};
  assign frame_len_want = SOF_BASE_LEN + comp_bytes;

  // Take a word whenever the skid entry is free.
  assign stream.ready = !skid_valid;
  assign accept       = stream.valid && stream.ready;
  assign take         = out_valid && report.ready;

  // Byte-level parse step: next state, and whether this word ends the parse.
  always_comb begin
    phase_next          = phase;
    segment_length_next = segment_length;
    bytes_to_skip_next  = bytes_to_skip;
    field_index_next    = field_index;
    high_byte_hold_next = high_byte_hold;
    width_reg_next      = width_reg;
    height_reg_next     = height_reg;
    precision_reg_next  = precision_reg;
    components_reg_next = components_reg;
    frame_code_reg_next = frame_code_reg;
    frame_flag_next     = frame_flag;
    emit                = 1'b0;
    status              = ST_OK;

    unique case (phase)
      PH_FF1: begin
        if (b != MARK_PREFIX) begin
          emit   = 1'b1;
          status = ST_START;
        end else begin
          phase_next = PH_SOI;
        end
      end
      PH_SOI: begin
        if (b != MARK_SOI) begin
          emit   = 1'b1;
          status = ST_START;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_HUNT: begin
        if (b == MARK_PREFIX) phase_next = PH_CODE;
      end
      PH_CODE: begin
        // Pad bytes (repeated FF) keep us here.
        priority if (b == MARK_PREFIX) begin
          phase_next = PH_CODE;
        end else if (b == MARK_SOS || b == MARK_EOI) begin
          emit   = 1'b1;
          status = ST_OK;
        end else if (is_frame_code(b)) begin
          frame_code_reg_next = b;
          phase_next          = PH_FLEN_H;
        end else begin
          phase_next = PH_SKLEN_H;
        end
      end
      PH_SKLEN_H: begin
        high_byte_hold_next = b;
        phase_next          = PH_SKLEN_L;
      end
      PH_SKLEN_L: begin
        segment_length_next = len_word;
        if (len_word < 16'd2) begin
          emit   = 1'b1;
          status = ST_LEN;
        end else begin
          bytes_to_skip_next = len_word - 16'd2;
          phase_next         = (len_word == 16'd2) ? PH_HUNT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_to_skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = PH_HUNT;
      end
      PH_FLEN_H: begin
        high_byte_hold_next = b;
        phase_next          = PH_FLEN_L;
      end
      PH_FLEN_L: begin
        segment_length_next = len_word;
        field_index_next    = FLD_PRECISION;
        phase_next          = PH_FIELDS;
      end
      PH_FIELDS: begin
        field_index_next = field_index + 3'd1;
        unique case (field_index)
          FLD_PRECISION: precision_reg_next  = b;
          FLD_HEIGHT_H:  high_byte_hold_next = b;
          FLD_HEIGHT_L:  height_reg_next     = len_word;
          FLD_WIDTH_H:   high_byte_hold_next = b;
          FLD_WIDTH_L:   width_reg_next      = len_word;
          default: begin
            // Component count: check the length, then skip the entries.
            components_reg_next = b;
            field_index_next    = FLD_PRECISION;
            if (segment_length != {6'd0, frame_len_want}) begin
              emit   = 1'b1;
              status = ST_LEN;
            end else begin
              frame_flag_next    = 1'b1;
              bytes_to_skip_next = {6'd0, comp_bytes};
              phase_next         = (comp_bytes == 10'd0) ? PH_HUNT : PH_SKIP;
            end
          end
        endcase
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (emit) phase_next = PH_DONE;

    // End of data overrides the byte step; report truncation unless done.
    if (eod) begin
      emit   = (phase != PH_DONE);
      status = ST_TRUNC;
    end
  end

  // Truncation reports the registers as they stand; otherwise the updated ones.
  always_comb begin
    result_word.parse_status = status;
    if (eod) begin
      result_word.frame_seen       = frame_flag;
      result_word.image_width      = width_reg;
      result_word.image_height     = height_reg;
      result_word.sample_precision = precision_reg;
      result_word.component_count  = components_reg;
      result_word.frame_kind       = frame_code_reg;
    end else begin
      result_word.frame_seen       = frame_flag_next;
      result_word.image_width      = width_reg_next;
      result_word.image_height     = height_reg_next;
      result_word.sample_precision = precision_reg_next;
      result_word.component_count  = components_reg_next;
      result_word.frame_kind       = frame_code_reg_next;
    end
  end

  // Advance the parser on each accepted word; end of data starts a new file.
  always_ff @(posedge clk) begin
    if (rst || (accept && eod)) begin
      phase          <= PH_FF1;
      segment_length <= '0;
      bytes_to_skip  <= '0;
      field_index    <= '0;
      high_byte_hold <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      precision_reg  <= '0;
      components_reg <= '0;
      frame_code_reg <= '0;
      frame_flag     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      segment_length <= segment_length_next;
      bytes_to_skip  <= bytes_to_skip_next;
      field_index    <= field_index_next;
      high_byte_hold <= high_byte_hold_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      precision_reg  <= precision_reg_next;
      components_reg <= components_reg_next;
      frame_code_reg <= frame_code_reg_next;
      frame_flag     <= frame_flag_next;
    end
  end

  // Output register and skid entry: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid entry: payload
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept && emit) begin
        out_word <= result_word;
      end
    end else if (accept && emit) begin
      skid_word <= result_word;
    end
  end

  assign report.valid = out_valid;
  assign report.data  = out_word;

  // The skid entry fills only behind a stalled output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  // A result from a byte parks the parser until end of data.
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && !eod) |=> (phase == PH_DONE))
    else $error("parser did not stop after giving a result");

  // End of data always rewinds to the start of a file.
  a_eod_rewinds: assert property (@(posedge clk) disable iff (rst)
    (accept && eod) |=> (phase == PH_FF1 && frame_flag == 1'b0))
    else $error("end of data did not return the parser to its start");

  // A frame counts as seen only with a start-of-frame code recorded.
  a_frame_has_code: assert property (@(posedge clk) disable iff (rst)
    frame_flag |-> is_frame_code(frame_code_reg))
    else $error("frame flag set without a start-of-frame code");

endmodule

/* tb/jpeg_marker_scan_dimensions_core_test.sv */
module jpeg_marker_scan_dimensions_core_test
  import jmsd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Marker codes the stimulus needs that the package does not name.
  localparam logic [7:0] MARK_COM = 8'hFE;

  // Run length and the watchdog. The slowest correct run (every word after
  // a full idle burst, every report after a full stall, the long hold-off and
  // the odd 255-component frame) stays far below the limit.
  localparam int unsigned TARGET_WORDS = 1550;
  localparam int unsigned QUIET_AFTER  = 1250;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the parse of the byte stream, keeps the reports it
  // predicts in arrival order, and checks each report the block hands out.
  // --------------------------------------------------------------------------
  class marker_scan_scoreboard;
    phase_t      phase;
    logic [15:0] seg_len;
    logic [15:0] skip_left;
    logic [2:0]  field_idx;
    logic [7:0]  hold_byte;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  precision;
    logic [7:0]  components;
    logic [7:0]  frame_code;
    logic        frame_ok;

    out_word_t   expected_reports[$];
    int unsigned mismatches;
    int unsigned status_hits[4];
    int unsigned frames_reported;

    function new();
      clear_parse();
      mismatches = 0;
      frames_reported = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void clear_parse();
      phase      = PH_FF1;
      seg_len    = '0;
      skip_left  = '0;
      field_idx  = '0;
      hold_byte  = '0;
      width      = '0;
      height     = '0;
      precision  = '0;
      components = '0;
      frame_code = '0;
      frame_ok   = 1'b0;
    endfunction

    // SOFn: high nibble C, except the DHT/JPG/DAC codes (low two bits zero,
    // low nibble nonzero).
    function bit frame_marker(logic [7:0] c);
      return (c[7:4] == 4'hC) && !((c[1:0] == 2'b00) && (c[3:2] != 2'b00));
    endfunction

    // A report carries whatever the header registers hold right now.
    function void post_report(status_t st);
      out_word_t r;
      r.parse_status     = st;
      r.frame_seen       = frame_ok;
      r.image_width      = width;
      r.image_height     = height;
      r.sample_precision = precision;
      r.component_count  = components;
      r.frame_kind       = frame_code;
      expected_reports.push_back(r);
      phase = PH_DONE;
    endfunction

    function void begin_skip(logic [15:0] n);
      skip_left = n;
      phase = (n == 16'd0) ? PH_HUNT : PH_SKIP;
    endfunction

    // Advance the parse by one accepted input word.
    function void note_word(in_word_t w);
      logic [7:0]  b;
      logic [15:0] comp_bytes;
      b = w.data_byte;
      if (w.end_of_data) begin
        if (phase != PH_DONE) post_report(ST_TRUNC);
        clear_parse();
        return;
      end
      case (phase)
        PH_FF1: begin
          if (b != MARK_PREFIX) post_report(ST_START);
          else phase = PH_SOI;
        end
        PH_SOI: begin
          if (b != MARK_SOI) post_report(ST_START);
          else phase = PH_HUNT;
        end
        PH_HUNT: begin
          if (b == MARK_PREFIX) phase = PH_CODE;
        end
        PH_CODE: begin
          // Pad bytes keep us here.
          if (b != MARK_PREFIX) begin
            if (b == MARK_SOS || b == MARK_EOI) begin
              post_report(ST_OK);
            end else if (frame_marker(b)) begin
              frame_code = b;
              phase = PH_FLEN_H;
            end else begin
              phase = PH_SKLEN_H;
            end
          end
        end
        PH_SKLEN_H: begin
          hold_byte = b;
          phase = PH_SKLEN_L;
        end
        PH_SKLEN_L: begin
          seg_len = {hold_byte, b};
          if (seg_len < 16'd2) post_report(ST_LEN);
          else begin_skip(seg_len - 16'd2);
        end
        PH_SKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) phase = PH_HUNT;
        end
        PH_FLEN_H: begin
          hold_byte = b;
          phase = PH_FLEN_L;
        end
        PH_FLEN_L: begin
          seg_len = {hold_byte, b};
          field_idx = '0;
          phase = PH_FIELDS;
        end
        PH_FIELDS: begin
          case (field_idx)
            FLD_PRECISION: precision = b;
            FLD_HEIGHT_H:  hold_byte = b;
            FLD_HEIGHT_L:  height = {hold_byte, b};
            FLD_WIDTH_H:   hold_byte = b;
            FLD_WIDTH_L:   width = {hold_byte, b};
            default: begin
              comp_bytes = {8'd0, b} * 16'd3;
              components = b;
              if (int'(seg_len) != int'(SOF_BASE_LEN) + int'(comp_bytes)) begin
                post_report(ST_LEN);
              end else begin
                frame_ok = 1'b1;
                begin_skip(comp_bytes);
              end
            end
          endcase
          // The count byte closes the header and rewinds the field index.
          if (field_idx > FLD_WIDTH_L) field_idx = '0;
          else field_idx = field_idx + 3'd1;
        end
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_report(out_word_t got);
      out_word_t want;
      bit        ok;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      status_hits[want.parse_status]++;
      if (want.frame_seen) frames_reported++;
      ok = 1'b1;
      ok &= field_ok("parse_status", 16'(want.parse_status), 16'(got.parse_status));
      ok &= field_ok("frame_seen", 16'(want.frame_seen), 16'(got.frame_seen));
      ok &= field_ok("image_width", want.image_width, got.image_width);
      ok &= field_ok("image_height", want.image_height, got.image_height);
      ok &= field_ok("sample_precision", 16'(want.sample_precision),
                     16'(got.sample_precision));
      ok &= field_ok("component_count", 16'(want.component_count),
                     16'(got.component_count));
      ok &= field_ok("frame_kind", 16'(want.frame_kind), 16'(got.frame_kind));
      if (!ok) mismatches++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  jmsd_stream_if #(.word_t(in_word_t))  in_bus ();
  jmsd_stream_if #(.word_t(out_word_t)) out_bus ();

  jpeg_marker_scan_dimensions_core u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (in_bus),
    .report (out_bus)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  marker_scan_scoreboard sb;

  // Shared between the two sides: idling on/off, and a one-shot request for
  // the receiver to hold off long enough that both output entries fill.
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  int unsigned words_sent = 0;
  int unsigned files_sent = 0;
  int unsigned cycle_count = 0;

  // Bytes of the file being assembled; send_file drains it.
  logic [7:0] file_bytes[$];

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word, optionally after an idle burst, and hold it until taken.
  // Drive at the falling edge, sample the handshake at the rising edge.
  task automatic send_word(logic [7:0] b, logic eod);
    in_word_t w;
    int       gap;
    w.data_byte   = b;
    w.end_of_data = eod;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  // Send the assembled bytes, then the end-of-data word with a random byte
  // riding along (the block must ignore it).
  task automatic send_file();
    foreach (file_bytes[i]) send_word(file_bytes[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    file_bytes.delete();
    files_sent++;
  endtask

  // Mostly ordinary sizes, with the all-zero and all-one extremes mixed in.
  function automatic logic [15:0] pick_dimension();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Frame header with a random SOFn code. Length is right most of the time;
  // otherwise the block must flag it on the count byte.
  task automatic add_frame_segment();
    logic [7:0]  code;
    logic [7:0]  n;
    logic [15:0] len;
    logic [15:0] dim;
    code = 8'hC0 | 8'($urandom_range(0, 15));
    // Fold DHT/JPG/DAC onto their odd neighbours, which are frame codes.
    if (code[1:0] == 2'b00 && code[3:2] != 2'b00) code[0] = 1'b1;
    n = ($urandom_range(0, 79) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
    len = 16'd8 + 16'd3 * {8'd0, n};
    if ($urandom_range(0, 5) == 0) len = 16'($urandom_range(0, 40));
    file_bytes.push_back(code);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    dim = pick_dimension();
    file_bytes.push_back(dim[15:8]);
    file_bytes.push_back(dim[7:0]);
    dim = pick_dimension();
    file_bytes.push_back(dim[15:8]);
    file_bytes.push_back(dim[7:0]);
    file_bytes.push_back(n);
    repeat (3 * int'(n)) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Any other marker with a short body to skip; now and then a length
  // below two, which must be rejected.
  task automatic add_other_segment();
    logic [7:0]  code;
    logic [15:0] len;
    do begin
      code = 8'($urandom_range(0, 255));
    end while (code == MARK_PREFIX || code == MARK_SOS || code == MARK_EOI ||
               sb.frame_marker(code));
    len = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(0, 1))
                                       : 16'($urandom_range(2, 12));
    file_bytes.push_back(code);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
    if (len >= 16'd2) repeat (int'(len) - 2) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // SOI, a few segments with stray bytes and pad bytes between them, then SOS
  // or EOI and some trailing bytes that come after the report.
  task automatic build_well_formed();
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(MARK_SOI);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 254)));
      file_bytes.push_back(MARK_PREFIX);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) file_bytes.push_back(MARK_PREFIX);
      if ($urandom_range(0, 1) == 0) add_frame_segment();
      else add_other_segment();
    end
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(($urandom_range(0, 1) == 0) ? MARK_SOS : MARK_EOI);
    repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Short files that each cause one report; used while the receiver stalls.
  task automatic send_short_file();
    if ($urandom_range(0, 1) == 0) file_bytes.push_back(8'($urandom_range(0, 254)));
    send_file();
  endtask

  initial begin
    int unsigned cut;
    int unsigned idx;
    bit          hold_done;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    rst = 1'b1;
    hold_done = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty file, bad first byte, bad second byte, a segment with length
    // zero that must be rejected, followed by an ignored byte, a frame header cut
    // short, and a scan start right after SOI.
    send_file();
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{MARK_PREFIX, MARK_PREFIX};
    send_file();
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_COM, 8'h00, 8'h00, MARK_PREFIX};
    send_file();
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOF_HI};
    send_file();
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_SOS};
    send_file();

    // Random files: mostly well formed, the rest cut short, corrupted in one
    // byte, or plain noise.
    while (words_sent < TARGET_WORDS) begin
      if (!hold_done && words_sent > HOLD_AT) begin
        // Stall the receiver and keep pushing report-causing files so the
        // output fills and the input has to stall.
        long_hold_req = 1'b1;
        repeat (12) send_short_file();
        hold_done = 1'b1;
      end
      if (words_sent > QUIET_AFTER) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        7: begin
          build_well_formed();
          cut = $urandom_range(0, file_bytes.size() - 1);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        8: begin
          build_well_formed();
          idx = $urandom_range(0, file_bytes.size() - 1);
          file_bytes[idx] = 8'($urandom_range(0, 255));
        end
        9: begin
          if ($urandom_range(0, 1) == 0) begin
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_SOI);
          end
          repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: build_well_formed();
      endcase
      send_file();
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Drain, then give the block a few more cycles to show any stray report.
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d files; %0d reports carried a parsed frame.",
             words_sent, files_sent, sb.frames_reported);
    $display("Reports by status: ok %0d, bad start %0d, bad length %0d, truncated %0d.",
             sb.status_hits[ST_OK], sb.status_hits[ST_START],
             sb.status_hits[ST_LEN], sb.status_hits[ST_TRUNC]);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off on request, and always
  // ready once idling is switched off.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    out_bus.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_bus.ready <= 1'b0;
        hold_left = $urandom_range(0, 10);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Check every report word at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) sb.check_report(out_bus.data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
